[src/dpu_pkg.sv]
// shared constants, types and register reset values for the depth pixel unprojection unit
package dpu_pkg;

   localparam int COORD_BITS = 12;
   localparam int DEPTH_BITS = 24;
   localparam int COEF_W     = 32;
   localparam int NUM_REGS   = 8;
   localparam int REG_W      = 64;
   localparam int IDX_W      = 4;
   localparam int FRAC_BITS  = 16;
   localparam int SUM_W      = 56;
   localparam int MAG_W      = SUM_W - 1;
   localparam int REM_W      = MAG_W + 1;
   localparam int QUO_W      = 32;
   localparam int FEED_W     = 2 * FRAC_BITS;
   localparam int DIV_STEPS  = QUO_W;
   localparam int OUT_W      = 32;
   localparam int XY_SHIFT   = 24 - FRAC_BITS;
   localparam int D_SHIFT    = DEPTH_BITS - XY_SHIFT;
   localparam int XP_W       = COEF_W + COORD_BITS;
   localparam int DP_W       = COEF_W + DEPTH_BITS + 1;

   localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = {DEPTH_BITS{1'b1}};

   // matrix reset: identity
   localparam logic [REG_W-1:0] RESET_LO = 64'h0000_0000_0001_0000;
   localparam logic [REG_W-1:0] RESET_HI = 64'h0001_0000_0000_0000;
   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      RESET_LO, '0, RESET_HI, '0, '0, RESET_LO, '0, RESET_HI
   };

   // one divider request: numerator and divisor magnitudes, result sign
   typedef struct packed {
      logic [MAG_W-1:0] num;
      logic [MAG_W-1:0] den;
      logic             neg;
   } dpu_div_req_type;

   // one divider stage
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [MAG_W-1:0]  den;
      logic [FEED_W-1:0] feed;
      logic [QUO_W-1:0]  quo;
      logic              neg;
      logic              ovf;
   } dpu_div_stage_type;

endpackage

[src/dpu_div_lane.sv]
// pipelined restoring divider: one quotient bit per stage, Q16.16 saturated result
module dpu_div_lane import dpu_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  dpu_div_req_type         req,
   output logic [OUT_W-1:0]        quot
);

   dpu_div_stage_type st_ff [0:DIV_STEPS];
   dpu_div_stage_type st_in [0:DIV_STEPS];
   dpu_div_stage_type last;
   logic              big;

   // entry: integer part seeds the remainder, overflow when quotient reaches 2^32
   always_comb begin
      st_in[0].rem  = REM_W'(req.num >> FRAC_BITS);
      st_in[0].den  = req.den;
      st_in[0].feed = {req.num[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      st_in[0].quo  = '0;
      st_in[0].neg  = req.neg;
      st_in[0].ovf  = (req.num >> FRAC_BITS) >= req.den;
   end

   // one compare and subtract per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [REM_W-1:0] shifted;
      logic             geq;
      always_comb begin
         shifted = {st_ff[k].rem[REM_W-2:0], st_ff[k].feed[FEED_W-1]};
         geq     = shifted >= {1'b0, st_ff[k].den};
         st_in[k+1].rem  = geq ? shifted - {1'b0, st_ff[k].den} : shifted;
         st_in[k+1].den  = st_ff[k].den;
         st_in[k+1].feed = {st_ff[k].feed[FEED_W-2:0], 1'b0};
         st_in[k+1].quo  = {st_ff[k].quo[QUO_W-2:0], geq};
         st_in[k+1].neg  = st_ff[k].neg;
         st_in[k+1].ovf  = st_ff[k].ovf;
      end
   end

   // stage registers, all advance together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // sign and saturation
   always_comb begin
      last = st_ff[DIV_STEPS];
      big  = last.ovf | last.quo[QUO_W-1];
      if (!last.neg) begin
         quot = big ? SAT_POS : last.quo;
      end else begin
         quot = big ? SAT_NEG : OUT_W'(-last.quo);
      end
   end

endmodule

[src/depth_pixel_unprojection_unit.sv]
// depth pixel unprojection: pixel and depth in, saturated Q16.16 world point out
// throughput: one beat per cycle; five front stages feed three 33-stage dividers
// the whole pipeline holds when the output register is full and rsp_tready is low
// reset: synchronous, clears valid bits and loads the identity matrix
module depth_pixel_unprojection_unit import dpu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,   // pixel_col[11:0], pixel_row[23:12], depth_code[47:24]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [95:0]        rsp_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
   output logic [0:0]         rsp_tuser,   // has_point[0]
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [REG_W-1:0]   csr_wdata
);

   logic [REG_W-1:0] regs_ff [NUM_REGS];
   logic             en;

   logic [COORD_BITS-1:0] col_ff, row_ff;
   logic [DEPTH_BITS-1:0] dep_ff;
   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                  bg2_ff, bg3_ff, bg4_ff, has5_ff;

   logic signed [XP_W-1:0]   px_ff [4];
   logic signed [XP_W-1:0]   py_ff [4];
   logic signed [DP_W-1:0]   pd_ff [4];
   logic signed [COEF_W-1:0] pc_ff [4];
   logic signed [SUM_W-1:0]  ta_ff [4];
   logic signed [SUM_W-1:0]  tb_ff [4];
   logic signed [SUM_W-1:0]  sum_ff [4];

   dpu_div_req_type dreq_ff [3];
   logic [OUT_W-1:0] quot [3];

   logic side_v_ff [0:DIV_STEPS];
   logic side_h_ff [0:DIV_STEPS];

   logic             rsp_valid_ff;
   logic [95:0]      rsp_data_ff;
   logic             rsp_has_ff;

   logic signed [SUM_W-1:0] den_s;
   logic [MAG_W-1:0]        den_mag;

   // pipeline advances whenever the output register can take a beat
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= REG_RESET[i];
      end else if (csr_we && csr_index < IDX_W'(NUM_REGS)) begin
         regs_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) side_v_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         side_v_ff[0] <= v5_ff;
         for (int k = 1; k <= DIV_STEPS; k++) side_v_ff[k] <= side_v_ff[k-1];
         rsp_valid_ff <= side_v_ff[DIV_STEPS];
      end
   end

   // stage 1: capture the beat
   always_ff @(posedge clock) begin
      if (en) begin
         col_ff <= req_tdata[COORD_BITS-1:0];
         row_ff <= req_tdata[12 +: COORD_BITS];
         dep_ff <= req_tdata[24 +: DEPTH_BITS];
      end
   end

   // stage 2: products per row; stage 3: pair sums; stage 4: row sums
   for (genvar r = 0; r < 4; r++) begin : g_row
      logic signed [COEF_W-1:0] c0, c1, c2, c3;
      assign c0 = regs_ff[2*r][COEF_W-1:0];
      assign c1 = regs_ff[2*r][REG_W-1:COEF_W];
      assign c2 = regs_ff[2*r+1][COEF_W-1:0];
      assign c3 = regs_ff[2*r+1][REG_W-1:COEF_W];
      always_ff @(posedge clock) begin
         if (en) begin
            px_ff[r]  <= XP_W'(c0) * XP_W'($signed({1'b0, col_ff}));
            py_ff[r]  <= XP_W'(c1) * XP_W'($signed({1'b0, row_ff}));
            pd_ff[r]  <= DP_W'(c2) * DP_W'($signed({1'b0, dep_ff}));
            pc_ff[r]  <= c3;
            ta_ff[r]  <= (SUM_W'(px_ff[r]) <<< XY_SHIFT) + (SUM_W'(py_ff[r]) <<< XY_SHIFT);
            tb_ff[r]  <= SUM_W'(pd_ff[r] >>> D_SHIFT) + (SUM_W'(pc_ff[r]) <<< XY_SHIFT);
            sum_ff[r] <= ta_ff[r] + tb_ff[r];
         end
      end
   end

   // background flag follows the data
   always_ff @(posedge clock) begin
      if (en) begin
         bg2_ff <= dep_ff == DEPTH_FULL;
         bg3_ff <= bg2_ff;
         bg4_ff <= bg3_ff;
      end
   end

   // stage 5: magnitudes and signs for the dividers
   assign den_s   = sum_ff[3];
   assign den_mag = den_s[SUM_W-1] ? MAG_W'(-den_s) : MAG_W'(den_s);

   always_ff @(posedge clock) begin
      if (en) begin
         has5_ff <= !bg4_ff && den_s != '0;
         for (int r = 0; r < 3; r++) begin
            dreq_ff[r].num <= sum_ff[r][SUM_W-1] ? MAG_W'(-sum_ff[r]) : MAG_W'(sum_ff[r]);
            dreq_ff[r].den <= den_mag;
            dreq_ff[r].neg <= sum_ff[r][SUM_W-1] != den_s[SUM_W-1];
         end
      end
   end

   // dividers, one per coordinate
   for (genvar r = 0; r < 3; r++) begin : g_div
      dpu_div_lane u_div (
         .clock (clock),
         .en    (en),
         .req   (dreq_ff[r]),
         .quot  (quot[r])
      );
   end

   // has_point delay line alongside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         side_h_ff[0] <= has5_ff;
         for (int k = 1; k <= DIV_STEPS; k++) side_h_ff[k] <= side_h_ff[k-1];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_has_ff  <= side_h_ff[DIV_STEPS];
         rsp_data_ff <= side_h_ff[DIV_STEPS] ? {quot[2], quot[1], quot[0]} : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_has_ff;

endmodule

[src/dpu_checker.sv]
// port-level checks for the depth pixel unprojection unit, bound to the top level
module dpu_checker import dpu_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [95:0]      rsp_tdata,
   input logic [0:0]       rsp_tuser
);

   // a beat without a point carries a zero point
   a_nopoint_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("rsp beat without point has nonzero data");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   // empty output never blocks an offered req beat
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind depth_pixel_unprojection_unit dpu_checker u_dpu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[bench/dpu_checker.sv]
// checker for the depth pixel unprojection unit: watches the channels, predicts and compares
module dpu_scoreboard import dpu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [47:0]      req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [95:0]      rsp_tdata,
   input  logic [0:0]       rsp_tuser,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0] csr_wdata,
   output int               error_count,
   output int               points_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic        hit;
   } world_point_type;

   logic [REG_W-1:0] matrix_regs [NUM_REGS];
   world_point_type  point_queue [$];

   // signed coefficient at row r, column c
   function automatic longint coef_at(int r, int c);
      logic [REG_W-1:0] word;
      word = matrix_regs[r * 2 + c / 2];
      return longint'($signed(c % 2 ? word[63:32] : word[31:0]));
   endfunction

   // row sum in units of 2^-24; depth term floored
   function automatic longint row_total(int r, longint x, longint y, longint d);
      longint s;
      s = coef_at(r, 0) * x * 256 + coef_at(r, 1) * y * 256;
      s += (coef_at(r, 2) * d) >>> (DEPTH_BITS - 8);
      s += coef_at(r, 3) * 256;
      return s;
   endfunction

   // num/den as saturated Q16.16, truncated toward zero
   function automatic logic [31:0] q16_divide(longint num, longint den);
      logic neg;
      longint unsigned a, b, qi, rm, fr, mag;
      neg = (num < 0) != (den < 0);
      a = num < 0 ? -num : num;
      b = den < 0 ? -den : den;
      qi = a / b;
      rm = a % b;
      fr = 0;
      for (int i = 0; i < 16; i++) begin
         rm = rm << 1;
         fr = fr << 1;
         if (rm >= b) begin
            rm -= b;
            fr |= 1;
         end
      end
      if (qi > 64'h10000) qi = 64'h10000;
      mag = (qi << 16) | fr;
      if (!neg) return mag > 64'h7FFFFFFF ? SAT_POS : mag[31:0];
      if (mag > 64'h80000000) mag = 64'h80000000;
      return 32'(-mag);
   endfunction

   function automatic world_point_type unproject(logic [47:0] beat);
      world_point_type p;
      longint x, y, d, w;
      x = beat[11:0];
      y = beat[23:12];
      d = beat[47:24];
      p = '0;
      if (beat[47:24] == DEPTH_FULL) return p;
      w = row_total(3, x, y, d);
      if (w == 0) return p;
      p.px  = q16_divide(row_total(0, x, y, d), w);
      p.py  = q16_divide(row_total(1, x, y, d), w);
      p.pz  = q16_divide(row_total(2, x, y, d), w);
      p.hit = 1'b1;
      return p;
   endfunction

   // register writes, prediction on req beats, compare on rsp beats
   always @(posedge clock) begin
      world_point_type want, got;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] <= REG_RESET[i];
         point_queue.delete();
         error_count <= 0;
      end else begin
         if (csr_we && csr_index < NUM_REGS) matrix_regs[csr_index[2:0]] <= csr_wdata;
         if (req_tvalid && req_tready) point_queue = {point_queue, unproject(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser[0]};
            if (point_queue.size() == 0) begin
               $display("%0t: unexpected rsp beat %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = point_queue.pop_front();
               if (want != got) begin
                  $display("%0t: mismatch x exp %h act %h, y exp %h act %h,", $time,
                     want.px, got.px, want.py, got.py);
                  $display("%0t:   z exp %h act %h, hit exp %b act %b", $time,
                     want.pz, got.pz, want.hit, got.hit);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      points_pending = point_queue.size();
   end

endmodule

[bench/tb_top.sv]
// top of the depth pixel unprojection testbench: clock, reset, stimulus and verdict
module tb_top;
   import dpu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [47:0]      req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [95:0]      rsp_tdata;
   logic [0:0]       rsp_tuser;
   logic             csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_wdata = '0;
   int               error_count;
   int               points_pending;
   int               burst_left = 0;
   int               stall_mode = 0;

   always #5 clock = ~clock;

   depth_pixel_unprojection_unit dut (.*);
   dpu_scoreboard checker_i (.*);

   // receiver: stall pattern changes mode now and then
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= $urandom_range(0, 7) == 0;
         default: rsp_tready <= $urandom_range(0, 7) != 0;
      endcase
   end

   // one req beat; valid stays high inside a burst
   task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [23:0] depth);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {depth, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drain the pipeline before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return SAT_POS;
         2: return SAT_NEG;
         3: return $urandom_range(0, 1) ? 32'h0001_0000 : -32'sh0001_0000;
         4: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [23:0] pick_depth();
      case ($urandom_range(0, 9))
         0: return DEPTH_FULL;
         1: return '0;
         2: return DEPTH_FULL - 24'd1;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_pixels(int count);
      for (int i = 0; i < count; i++) send_pixel(12'($urandom), 12'($urandom), pick_depth());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrix: field extremes, bit patterns, background
      send_pixel(12'd0, 12'd0, 24'd0);
      send_pixel(12'hFFF, 12'hFFF, DEPTH_FULL - 24'd1);
      send_pixel(12'hAAA, 12'h555, 24'hAAAAAA);
      send_pixel(12'h555, 12'hAAA, 24'h555555);
      send_pixel(12'd100, 12'd200, DEPTH_FULL);
      send_pixel(12'd1, 12'd4094, 24'h800000);
      drain();

      // zero divisor: empty bottom row
      write_reg(4'd6, '0);
      write_reg(4'd7, '0);
      send_pixel(12'd7, 12'd9, 24'd1234);
      send_pixel(12'hFFF, 12'hFFF, 24'd0);
      drain();

      // saturation both ways with a tiny divisor
      write_reg(4'd0, {32'h0, SAT_POS});
      write_reg(4'd2, {SAT_NEG, 32'h0});
      write_reg(4'd4, {32'h0, 32'h1});
      write_reg(4'd5, {32'h0, SAT_NEG});
      write_reg(4'd7, {32'h0000_0001, 32'h0});
      write_reg(4'd9, 64'($urandom));
      send_pixel(12'hFFF, 12'hFFF, 24'hFFFFFE);
      send_pixel(12'd1, 12'd1, 24'd0);
      send_pixel(12'd0, 12'd0, 24'd1);
      drain();
      random_pixels(150);
      drain();

      // random matrices (identity in the last phase), all registers rewritten each phase
      for (int phase = 0; phase < 8; phase++) begin
         for (int r = 0; r < NUM_REGS; r++) write_reg(IDX_W'(r), {pick_coef(), pick_coef()});
         if (phase == 7) begin
            for (int r = 0; r < NUM_REGS; r++) write_reg(IDX_W'(r), REG_RESET[r]);
         end
         if (phase % 3 == 0) write_reg(4'($urandom_range(8, 15)), {$urandom, $urandom});
         random_pixels(230);
         drain();
      end

      repeat (100) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
